// File: rtl/dgts_pkg.sv
// ----------------------------------------------------------------------------
// dgts_pkg - shared definitions for the dependency-gated task scoreboard
// Field widths, request kinds, outcome codes and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package dgts_pkg;

	// Field widths
	localparam int KIND_W    = 2;
	localparam int GEN_W     = 64;
	localparam int TASK_W    = 3;
	localparam int MATRIX_W  = 64;
	localparam int OUTCOME_W = 4;
	localparam int MASK_W    = 8;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 4;

	// Matrix layout: one row of ROW_STRIDE bits per task
	localparam int ROW_STRIDE = 8;

	// Default task count
	localparam int NUM_TASKS_DEF = 8;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_BEGIN    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ROUTE    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CANCEL   = 2'd3;

	// Outcome codes
	localparam logic [OUTCOME_W-1:0] OUT_OK             = 4'd0;
	localparam logic [OUTCOME_W-1:0] OUT_DEFER          = 4'd1;
	localparam logic [OUTCOME_W-1:0] OUT_STALE          = 4'd2;
	localparam logic [OUTCOME_W-1:0] OUT_CANCELLED      = 4'd3;
	localparam logic [OUTCOME_W-1:0] OUT_NOT_ACTIVE     = 4'd4;
	localparam logic [OUTCOME_W-1:0] OUT_DUPLICATE      = 4'd5;
	localparam logic [OUTCOME_W-1:0] OUT_NOT_ROUTED     = 4'd6;
	localparam logic [OUTCOME_W-1:0] OUT_GEN_ZERO       = 4'd7;
	localparam logic [OUTCOME_W-1:0] OUT_SELF_DEP       = 4'd8;
	localparam logic [OUTCOME_W-1:0] OUT_CYCLE          = 4'd9;
	localparam logic [OUTCOME_W-1:0] OUT_CANCEL_REFUSED = 4'd10;

	// Task status codes
	localparam logic [STATUS_W-1:0] STAT_PENDING     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_AVAILABLE   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_UNAVAILABLE = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;     // latch the accepted request, seed reachability
		logic reach_step;  // one closure iteration over the reachability rows
		logic commit;      // update scoreboard state and the result register
	} dgts_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [KIND_W-1:0] kind;
	} dgts_sts_t;

endpackage

`default_nettype wire

// File: rtl/dgts_if.sv
// ----------------------------------------------------------------------------
// dgts_if - request and result channels of the task scoreboard
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface dgts_req_if;
	logic                        valid;
	logic                        ready;
	logic [dgts_pkg::KIND_W-1:0] kind;
	logic [dgts_pkg::GEN_W-1:0]  generation;
	logic [dgts_pkg::TASK_W-1:0] task_index;
	logic                        available;

	modport source (output valid, kind, generation, task_index, available, input ready);
	modport sink   (input valid, kind, generation, task_index, available, output ready);
endinterface

interface dgts_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [dgts_pkg::OUTCOME_W-1:0] outcome;
	logic [dgts_pkg::MASK_W-1:0]    released_mask;
	logic [dgts_pkg::STATUS_W-1:0]  task_status;
	logic                           is_active;
	logic                           is_cancelled;
	logic [dgts_pkg::COUNT_W-1:0]   deferred_count;

	modport source (output valid, outcome, released_mask, task_status, is_active,
		is_cancelled, deferred_count, input ready);
	modport sink   (input valid, outcome, released_mask, task_status, is_active,
		is_cancelled, deferred_count, output ready);
endinterface

`default_nettype wire

// File: rtl/dgts_datapath.sv
// ----------------------------------------------------------------------------
// dgts_datapath - scoreboard state, reachability closure and result register
// Holds the matrix register, the lifecycle and task sets, and evaluates one
// request per commit. Reachability rows iterate one closure step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dgts_datapath #(
	parameter int NUM_TASKS = dgts_pkg::NUM_TASKS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// configuration
	input  wire                                 cfg_we,
	input  wire  [dgts_pkg::MATRIX_W-1:0]       cfg_wdata,
	// request payload
	input  wire  [dgts_pkg::KIND_W-1:0]         kind,
	input  wire  [dgts_pkg::GEN_W-1:0]          generation,
	input  wire  [dgts_pkg::TASK_W-1:0]         task_index,
	input  wire                                 available,
	// result payload
	output logic [dgts_pkg::OUTCOME_W-1:0]      outcome,
	output logic [dgts_pkg::MASK_W-1:0]         released_mask,
	output logic [dgts_pkg::STATUS_W-1:0]       task_status,
	output logic                                is_active,
	output logic                                is_cancelled,
	output logic [dgts_pkg::COUNT_W-1:0]        deferred_count,
	// control
	input  dgts_pkg::dgts_cmd_t                 cmd,
	output dgts_pkg::dgts_sts_t                 sts
);

	localparam int N = NUM_TASKS;

	// Configuration and latched request
	logic [dgts_pkg::MATRIX_W-1:0] cfg_q;
	logic [dgts_pkg::KIND_W-1:0]   kind_q;
	logic [dgts_pkg::GEN_W-1:0]    gen_q;
	logic [dgts_pkg::TASK_W-1:0]   task_q;
	logic                          avail_q;

	// Scoreboard state
	logic [dgts_pkg::GEN_W-1:0] cur_gen_q;
	logic                       active_q;
	logic                       cancelled_q;
	logic [N-1:0]               routed_q;
	logic [N-1:0]               deferred_q;
	logic [N-1:0]               completed_q;
	logic [N-1:0]               avail_set_q;
	logic [N-1:0]               plan_q [N];
	logic [N-1:0]               reach_q [N];

	// Next-state and result values
	logic [N-1:0]                    cfg_row [N];
	logic [N-1:0]                    reach_nxt [N];
	logic                            self_dep;
	logic                            cyclic;
	logic                            in_range;
	logic [N-1:0]                    tbit;
	logic [N-1:0]                    settled_now;
	logic [N-1:0]                    settled_after;
	logic                            gen_match;
	logic                            begin_ok;
	logic [dgts_pkg::OUTCOME_W-1:0]  outcome_d;
	logic [N-1:0]                    released_d;
	logic                            active_d;
	logic                            cancelled_d;
	logic [N-1:0]                    routed_d;
	logic [N-1:0]                    deferred_d;
	logic [N-1:0]                    completed_d;
	logic [N-1:0]                    avail_set_d;
	logic [dgts_pkg::STATUS_W-1:0]   status_d;
	logic [dgts_pkg::COUNT_W-1:0]    count_d;

	// kind of the request on offer, for the sequencer's branch at acceptance
	assign sts.kind = kind;

	// Matrix rows and closure step
	always_comb begin
		for (int p = 0; p < N; p++) begin
			cfg_row[p] = cfg_q[p*dgts_pkg::ROW_STRIDE +: N];
		end
		for (int p = 0; p < N; p++) begin
			reach_nxt[p] = reach_q[p];
			for (int q = 0; q < N; q++) begin
				if (reach_q[p][q]) begin
					reach_nxt[p] = reach_nxt[p] | reach_q[q];
				end
			end
		end
		self_dep = 1'b0;
		cyclic   = 1'b0;
		for (int p = 0; p < N; p++) begin
			self_dep = self_dep | cfg_row[p][p];
			cyclic   = cyclic | reach_q[p][p];
		end
	end

	// Addressed task and settledness
	always_comb begin
		in_range  = {1'b0, task_q} < (dgts_pkg::TASK_W+1)'(N);
		tbit      = in_range ? (N'(1) << task_q) : '0;
		gen_match = gen_q == cur_gen_q;
		for (int p = 0; p < N; p++) begin
			settled_now[p]   = ~|(plan_q[p] & ~completed_q);
			settled_after[p] = ~|(plan_q[p] & ~(completed_q | tbit));
		end
	end

	// Request evaluation
	always_comb begin
		outcome_d   = dgts_pkg::OUT_OK;
		released_d  = '0;
		begin_ok    = 1'b0;
		active_d    = active_q;
		cancelled_d = cancelled_q;
		routed_d    = routed_q;
		deferred_d  = deferred_q;
		completed_d = completed_q;
		avail_set_d = avail_set_q;
		unique case (kind_q)
			dgts_pkg::KIND_BEGIN: begin
				if (gen_q == '0) begin
					outcome_d = dgts_pkg::OUT_GEN_ZERO;
				end else if (self_dep) begin
					outcome_d = dgts_pkg::OUT_SELF_DEP;
				end else if (cyclic) begin
					outcome_d = dgts_pkg::OUT_CYCLE;
				end else begin
					begin_ok    = 1'b1;
					active_d    = 1'b1;
					cancelled_d = 1'b0;
					routed_d    = '0;
					deferred_d  = '0;
					completed_d = '0;
					avail_set_d = '0;
				end
			end
			dgts_pkg::KIND_ROUTE: begin
				if (!gen_match) begin
					outcome_d = dgts_pkg::OUT_STALE;
				end else if (cancelled_q) begin
					outcome_d = dgts_pkg::OUT_CANCELLED;
				end else if (!active_q) begin
					outcome_d = dgts_pkg::OUT_NOT_ACTIVE;
				end else if (!in_range) begin
					outcome_d = dgts_pkg::OUT_NOT_ROUTED;
				end else if (|((completed_q | routed_q) & tbit)) begin
					outcome_d = dgts_pkg::OUT_DUPLICATE;
				end else if (|(deferred_q & tbit)) begin
					outcome_d = dgts_pkg::OUT_DEFER;
				end else if (!(|(settled_now & tbit))) begin
					outcome_d  = dgts_pkg::OUT_DEFER;
					deferred_d = deferred_q | tbit;
				end else begin
					routed_d = routed_q | tbit;
				end
			end
			dgts_pkg::KIND_COMPLETE: begin
				if (!gen_match) begin
					outcome_d = dgts_pkg::OUT_STALE;
				end else if (cancelled_q) begin
					outcome_d = dgts_pkg::OUT_CANCELLED;
				end else if (!active_q) begin
					outcome_d = dgts_pkg::OUT_NOT_ACTIVE;
				end else if (!(|(routed_q & tbit))) begin
					outcome_d = dgts_pkg::OUT_NOT_ROUTED;
				end else begin
					routed_d    = routed_q & ~tbit;
					completed_d = completed_q | tbit;
					avail_set_d = avail_q ? (avail_set_q | tbit) : avail_set_q;
					released_d  = deferred_q & settled_after;
					deferred_d  = deferred_q & ~released_d;
				end
			end
			dgts_pkg::KIND_CANCEL: begin
				if (!active_q || !gen_match) begin
					outcome_d = dgts_pkg::OUT_CANCEL_REFUSED;
				end else begin
					active_d    = 1'b0;
					cancelled_d = 1'b1;
					routed_d    = '0;
					deferred_d  = '0;
				end
			end
		endcase
	end

	// Reported status and deferred population after the step
	always_comb begin
		if (|(completed_d & tbit)) begin
			status_d = (|(avail_set_d & tbit)) ? dgts_pkg::STAT_AVAILABLE
			                                   : dgts_pkg::STAT_UNAVAILABLE;
		end else begin
			status_d = dgts_pkg::STAT_PENDING;
		end
		count_d = '0;
		for (int p = 0; p < N; p++) begin
			count_d = count_d + dgts_pkg::COUNT_W'(deferred_d[p]);
		end
	end

	// Matrix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// Request latch and reachability rows
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			gen_q   <= generation;
			task_q  <= task_index;
			avail_q <= available;
			for (int p = 0; p < N; p++) begin
				reach_q[p] <= cfg_row[p];
			end
		end else if (cmd.reach_step) begin
			for (int p = 0; p < N; p++) begin
				reach_q[p] <= reach_nxt[p];
			end
		end
	end

	// Scoreboard state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_gen_q   <= '0;
			active_q    <= 1'b0;
			cancelled_q <= 1'b0;
			routed_q    <= '0;
			deferred_q  <= '0;
			completed_q <= '0;
			avail_set_q <= '0;
			for (int p = 0; p < N; p++) begin
				plan_q[p] <= '0;
			end
		end else if (cmd.commit) begin
			active_q    <= active_d;
			cancelled_q <= cancelled_d;
			routed_q    <= routed_d;
			deferred_q  <= deferred_d;
			completed_q <= completed_d;
			avail_set_q <= avail_set_d;
			if (begin_ok) begin
				cur_gen_q <= gen_q;
				for (int p = 0; p < N; p++) begin
					plan_q[p] <= cfg_row[p];
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			outcome        <= outcome_d;
			released_mask  <= dgts_pkg::MASK_W'(released_d);
			task_status    <= status_d;
			is_active      <= active_d;
			is_cancelled   <= cancelled_d;
			deferred_count <= count_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/dgts_ctrl.sv
// ----------------------------------------------------------------------------
// dgts_ctrl - request sequencer for the task scoreboard
// Accepts a request, runs the closure iterations for a begin, then commits
// into the result register as soon as that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module dgts_ctrl #(
	parameter int NUM_TASKS = dgts_pkg::NUM_TASKS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire                  out_ready,
	input  dgts_pkg::dgts_sts_t  sts,
	output dgts_pkg::dgts_cmd_t  cmd
);

	localparam int CNT_W = $clog2(NUM_TASKS);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_TASKS - 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_CLOSE  = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0]       state_q;
	logic [1:0]       state_d;
	logic [CNT_W-1:0] step_q;
	logic             out_valid_q;
	logic             accept;
	logic             slot_free;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	// Commands
	assign cmd.capture    = accept;
	assign cmd.reach_step = state_q == ST_CLOSE;
	assign cmd.commit     = (state_q == ST_COMMIT) && slot_free;

	// Next state; a begin runs the closure steps first
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (sts.kind == dgts_pkg::KIND_BEGIN) begin
						state_d = ST_CLOSE;
					end else begin
						state_d = ST_COMMIT;
					end
				end
			end
			ST_CLOSE: begin
				if (step_q == LAST_STEP) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, step counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= '0;
			end else if (state_q == ST_CLOSE) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Checks
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.reach_step, cmd.commit}))
		else $error("more than one datapath command in a cycle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("request taken while the previous one is in flight");

	a_close_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLOSE) && (step_q == LAST_STEP) |=> state_q == ST_COMMIT)
		else $error("closure did not end after the last step");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid && in_ready)
		else $error("committed result not presented");

endmodule

`default_nettype wire

// File: rtl/dependency_gated_task_scoreboard.sv
// ----------------------------------------------------------------------------
// dependency_gated_task_scoreboard - prerequisite-gated task tracker
// Usage:
//   req carries one request (kind, generation, task_index, available); rsp
//   returns exactly one result per request. cfg_we/cfg_wdata write the
//   dependency matrix; write it only while no request is outstanding.
//   A request is taken only while the block is idle. Route, complete and
//   cancel pass from acceptance to the commit state and on to the result
//   register; begin first passes through the closure state, since the
//   cycle check runs one reachability closure step per cycle over all
//   rows in parallel, NUM_TASKS steps. The result register parts the two
//   sides: a new request is taken while a result waits; if rsp stays
//   stalled, the next result is held back in the sequencer until the
//   register frees, and req.ready stays low. Reset (arst_n low) clears
//   the matrix, generation, lifecycle flags and all task sets at once;
//   the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module dependency_gated_task_scoreboard #(
	parameter int NUM_TASKS = dgts_pkg::NUM_TASKS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [dgts_pkg::MATRIX_W-1:0]    cfg_wdata,
	dgts_req_if.sink                         req,
	dgts_rsp_if.source                       rsp
);

	dgts_pkg::dgts_cmd_t cmd;
	dgts_pkg::dgts_sts_t sts;

	dgts_ctrl #(
		.NUM_TASKS (NUM_TASKS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dgts_datapath #(
		.NUM_TASKS (NUM_TASKS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.kind           (req.kind),
		.generation     (req.generation),
		.task_index     (req.task_index),
		.available      (req.available),
		.outcome        (rsp.outcome),
		.released_mask  (rsp.released_mask),
		.task_status    (rsp.task_status),
		.is_active      (rsp.is_active),
		.is_cancelled   (rsp.is_cancelled),
		.deferred_count (rsp.deferred_count),
		.cmd            (cmd),
		.sts            (sts)
	);

endmodule

`default_nettype wire
